// File: design/pli_pkg.sv
package pli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int QUO_W      = 35;  // quotient bits kept; anything above forces saturation

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_ZERO_SPN = 2'd3;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_CLOSEST = 2'd1;
  localparam logic [1:0] MODE_TREND   = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // One divider stage's payload.
  typedef struct packed {
    logic              vld;
    logic              done;   // result already known, bypasses the arithmetic
    logic [1:0]        st;
    logic [31:0]       val;
    logic signed [31:0] y0;
    logic              neg;
    logic              ovf;
    logic [31:0]       dvs;
    logic [QUO_W-1:0]  lo;     // dividend bits still to shift in
    logic [31:0]       rem;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

endpackage

// File: design/piecewise_linear_interpolator_core.sv
// Channel   Dir  Transaction                    Payload
// in_*      in   load (no result) or query      cmd, point_index, point_x, point_y, query_value
// out_*     out  one per query                  result_value, status
// cfg_*     in   register write, no handshake   extrapolation_mode, point_count
//
// Queries run through 41 register stages: compare, segment select, differences,
// 32x32 multiply, a 36-stage restoring divider (entry check, then one quotient bit
// per stage), final sum. One transaction per cycle unless out_tready stalls.
// Loads write the table at accept and leave no result.
// Reset (rst_n low, synchronous) clears valid bits and the config registers; table is not cleared.
// A stall on out_tready freezes every stage together; in_tready follows it.
module piecewise_linear_interpolator_core
  import pli_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] cmd, [4:1] point_index, [36:5] point_x, [68:37] point_y,
  // [100:69] query_value, [103:101] zero
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] result_value, [33:32] status, [39:34] zero
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [4:0]   cfg_wdata
);

  localparam int NDIV = QUO_W + 1;

  logic [1:0]       mode_r;
  logic [CNT_W-1:0] count_r;
  logic signed [31:0] tx_r [MAX_POINTS];
  logic signed [31:0] ty_r [MAX_POINTS];

  logic advance;
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  logic               in_cmd;
  logic [IDX_W-1:0]   in_idx;
  logic signed [31:0] in_px, in_py, in_q;
  assign in_cmd = in_tdata[0];
  assign in_idx = in_tdata[4:1];
  assign in_px  = in_tdata[36:5];
  assign in_py  = in_tdata[68:37];
  assign in_q   = in_tdata[100:69];

  logic acc;
  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_MODE) mode_r <= cfg_wdata[1:0];
      else                      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_cmd == CMD_LOAD) begin
      tx_r[in_idx] <= in_px;
      ty_r[in_idx] <= in_py;
    end
  end

  // ---- stage 1: compare query against every breakpoint
  logic [CNT_W-1:0] n_c;
  logic [MAX_POINTS-2:0] seg_c;
  logic eqn_c;
  assign n_c = (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;

  always_comb begin
    seg_c = '0;
    eqn_c = 1'b0;
    for (int i = 0; i < MAX_POINTS - 1; i++)
      seg_c[i] = (CNT_W'(i + 1) < n_c) && (tx_r[i] <= in_q) && (tx_r[i + 1] >= in_q);
    for (int i = 0; i < MAX_POINTS; i++)
      if ((CNT_W'(i + 1) == n_c) && (tx_r[i] == in_q)) eqn_c = 1'b1;
  end

  logic                  s1_vld_r;
  logic [MAX_POINTS-2:0] s1_seg_r;
  logic                  s1_eq0_r, s1_eqn_r, s1_below_r, s1_few_r;
  logic [IDX_W-1:0]      s1_last_r;
  logic signed [31:0]    s1_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (advance) s1_vld_r <= acc && in_cmd == CMD_QUERY;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_seg_r   <= seg_c;
      s1_eq0_r   <= in_q == tx_r[0];
      s1_eqn_r   <= eqn_c;
      s1_below_r <= in_q <= tx_r[0];
      s1_few_r   <= n_c < CNT_W'(2);
      s1_last_r  <= IDX_W'(n_c - CNT_W'(1));
      s1_q_r     <= in_q;
    end
  end

  // ---- stage 2: pick the segment or the end result
  logic [IDX_W-1:0] lo_c, a_c, a1_c;
  logic found_c, done_c;
  logic [1:0]  st_c;
  logic [31:0] val_c;

  always_comb begin
    lo_c    = '0;
    found_c = 1'b0;
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (s1_seg_r[i]) begin
        lo_c    = IDX_W'(i);
        found_c = 1'b1;
      end
    end
    done_c = 1'b1;
    st_c   = ST_OK;
    val_c  = '0;
    a_c    = lo_c;
    if (s1_few_r) begin
      st_c = ST_FEW;
    end else if (found_c) begin
      done_c = 1'b0;
    end else if (s1_eq0_r) begin
      val_c = ty_r[0];
    end else if (s1_eqn_r) begin
      val_c = ty_r[s1_last_r];
    end else if (mode_r == MODE_CLOSEST) begin
      val_c = s1_below_r ? ty_r[0] : ty_r[s1_last_r];
    end else if (mode_r == MODE_TREND) begin
      done_c = 1'b0;
      a_c    = s1_below_r ? '0 : s1_last_r - IDX_W'(1);
    end else begin
      st_c = ST_RANGE;
    end
  end
  assign a1_c = a_c + IDX_W'(1);

  logic               s2_vld_r, s2_done_r;
  logic [1:0]         s2_st_r;
  logic [31:0]        s2_val_r;
  logic signed [31:0] s2_x0_r, s2_x1_r, s2_y0_r, s2_y1_r, s2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (advance) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_done_r <= done_c;
      s2_st_r   <= st_c;
      s2_val_r  <= val_c;
      s2_x0_r   <= tx_r[a_c];
      s2_x1_r   <= tx_r[a1_c];
      s2_y0_r   <= ty_r[a_c];
      s2_y1_r   <= ty_r[a1_c];
      s2_q_r    <= s1_q_r;
    end
  end

  // ---- stage 3: differences, signs, magnitudes
  logic signed [32:0] s_c, t_c, dy_c;
  assign s_c  = 33'(s2_x1_r) - 33'(s2_x0_r);
  assign t_c  = 33'(s2_q_r)  - 33'(s2_x0_r);
  assign dy_c = 33'(s2_y1_r) - 33'(s2_y0_r);

  logic               s3_vld_r, s3_done_r, s3_neg_r;
  logic [1:0]         s3_st_r;
  logic [31:0]        s3_val_r, s3_mt_r, s3_md_r, s3_ms_r;
  logic signed [31:0] s3_y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (advance) s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      if (!s2_done_r && s_c == '0) begin
        s3_done_r <= 1'b1;
        s3_st_r   <= ST_ZERO_SPN;
        s3_val_r  <= '0;
      end else begin
        s3_done_r <= s2_done_r;
        s3_st_r   <= s2_st_r;
        s3_val_r  <= s2_val_r;
      end
      s3_neg_r <= t_c[32] ^ dy_c[32] ^ s_c[32];
      s3_mt_r  <= t_c[32]  ? 32'(-t_c)  : t_c[31:0];
      s3_md_r  <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
      s3_ms_r  <= s_c[32]  ? 32'(-s_c)  : s_c[31:0];
      s3_y0_r  <= s2_y0_r;
    end
  end

  // ---- stage 4: product
  logic               s4_vld_r, s4_done_r, s4_neg_r;
  logic [1:0]         s4_st_r;
  logic [31:0]        s4_val_r, s4_ms_r;
  logic signed [31:0] s4_y0_r;
  logic [63:0]        s4_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (advance) s4_vld_r <= s3_vld_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_done_r <= s3_done_r;
      s4_st_r   <= s3_st_r;
      s4_val_r  <= s3_val_r;
      s4_neg_r  <= s3_neg_r;
      s4_ms_r   <= s3_ms_r;
      s4_y0_r   <= s3_y0_r;
      s4_p_r    <= 64'(s3_mt_r) * 64'(s3_md_r);
    end
  end

  // ---- divider: entry check, then one quotient bit per stage
  div_stage_t dv_r   [NDIV];
  div_stage_t dv_nxt [NDIV];

  always_comb begin
    dv_nxt[0].vld  = s4_vld_r;
    dv_nxt[0].done = s4_done_r;
    dv_nxt[0].st   = s4_st_r;
    dv_nxt[0].val  = s4_val_r;
    dv_nxt[0].y0   = s4_y0_r;
    dv_nxt[0].neg  = s4_neg_r;
    dv_nxt[0].dvs  = s4_ms_r;
    dv_nxt[0].rem  = 32'(s4_p_r[63:QUO_W]);
    dv_nxt[0].ovf  = 32'(s4_p_r[63:QUO_W]) >= s4_ms_r;  // quotient would need more bits
    dv_nxt[0].lo   = s4_p_r[QUO_W-1:0];
    dv_nxt[0].quo  = '0;
    for (int j = 1; j < NDIV; j++) begin
      logic [32:0] sh;
      sh = {dv_r[j-1].rem, dv_r[j-1].lo[QUO_W-1]};
      dv_nxt[j]    = dv_r[j-1];
      dv_nxt[j].lo = {dv_r[j-1].lo[QUO_W-2:0], 1'b0};
      if (sh >= {1'b0, dv_r[j-1].dvs}) begin
        dv_nxt[j].rem = 32'(sh - {1'b0, dv_r[j-1].dvs});
        dv_nxt[j].quo = {dv_r[j-1].quo[QUO_W-2:0], 1'b1};
      end else begin
        dv_nxt[j].rem = sh[31:0];
        dv_nxt[j].quo = {dv_r[j-1].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NDIV; j++) begin
      if (!rst_n) dv_r[j].vld <= 1'b0;
      else if (advance) dv_r[j] <= dv_nxt[j];
    end
  end

  // ---- final: signed sum and saturation
  div_stage_t  fin;
  logic signed [QUO_W+1:0] sum_c;
  logic [31:0] res_c;
  logic [1:0]  stat_c;
  localparam logic [QUO_W-1:0] QUO_LIM = QUO_W'(1) << (QUO_W - 1);

  assign fin = dv_r[NDIV-1];

  always_comb begin
    sum_c = fin.neg ? (QUO_W+2)'(fin.y0) - (QUO_W+2)'({2'b00, fin.quo})
                    : (QUO_W+2)'(fin.y0) + (QUO_W+2)'({2'b00, fin.quo});
    stat_c = fin.st;
    if (fin.done) begin
      res_c = fin.val;
    end else if (fin.ovf || fin.quo > QUO_LIM) begin
      res_c = fin.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (sum_c > (QUO_W+2)'(32'sh7fff_ffff)) begin
      res_c = 32'h7fff_ffff;
    end else if (sum_c < -(QUO_W+2)'(33'sh0_8000_0000)) begin
      res_c = 32'h8000_0000;
    end else begin
      res_c = sum_c[31:0];
    end
    if (stat_c != ST_OK) res_c = '0;
  end

  logic        out_vld_r;
  logic [31:0] out_res_r;
  logic [1:0]  out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (advance) out_vld_r <= fin.vld;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_c;
      out_st_r  <= stat_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_st_r, out_res_r};

endmodule
